>>> hdl/amrdf_pkg.sv
`timescale 1ns / 1ps
// Shared types, result codes and the AMR-NB frame size table for the payload deframer.
package amrdf_pkg;

   typedef logic [1:0] status_type;
   typedef logic [3:0] nibble_type;

   localparam status_type ST_SPEECH = 2'd0;
   localparam status_type ST_EMPTY  = 2'd1;
   localparam status_type ST_TRUNC  = 2'd2;
   localparam status_type ST_OVF    = 2'd3;

   typedef struct packed {
      nibble_type ft;
      logic       q;
   } entry_type;

   typedef struct packed {
      status_type status;
      logic [7:0] speech_byte;
      nibble_type frame_index;
      nibble_type frame_type;
      logic       quality;
      nibble_type requested_mode;
      logic       last_of_frame;
      logic       last_result;
   } result_type;

   // speech bits per frame for frame types 0..7
   localparam logic [7:0] MODE_BITS [8] = '{
      8'd95, 8'd103, 8'd118, 8'd134, 8'd148, 8'd159, 8'd204, 8'd244
   };

   localparam logic [7:0] OCTET_MASK = 8'hf8;

   function automatic logic [7:0] frame_len(input logic [2:0] ft, input logic aligned);
      logic [7:0] bits;
      bits = MODE_BITS[ft];
      return aligned ? ((bits + 8'd7) & OCTET_MASK) : bits;
   endfunction

endpackage

>>> hdl/amrdf_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for payload octets in and deframed results out.
interface amrdf_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] payload_byte;
   logic       end_of_packet;

   modport source (output valid, payload_byte, end_of_packet, input ready);
   modport sink   (input valid, payload_byte, end_of_packet, output ready);
endinterface

interface amrdf_rsp_if;
   logic                   valid;
   logic                   ready;
   amrdf_pkg::status_type  status;
   logic [7:0]             speech_byte;
   amrdf_pkg::nibble_type  frame_index;
   amrdf_pkg::nibble_type  frame_type;
   logic                   quality;
   amrdf_pkg::nibble_type  requested_mode;
   logic                   last_of_frame;
   logic                   last_result;

   modport source (output valid, status, speech_byte, frame_index, frame_type, quality,
                   requested_mode, last_of_frame, last_result, input ready);
   modport sink   (input valid, status, speech_byte, frame_index, frame_type, quality,
                   requested_mode, last_of_frame, last_result, output ready);
endinterface

>>> hdl/amr_rtp_payload_deframer_core.sv
`timescale 1ns / 1ps
// AMR-NB RTP payload deframer: CMR/TOC parser, entry table memory and speech byte output.
//
// req_if carries one payload octet per beat plus an end-of-packet flag. rsp_if returns
// result beats: speech bytes, empty-frame markers, truncation and table overflow flags,
// each tagged with frame index, FT, Q and the packet's CMR. csr_wr_en/csr_wr_data set
// octet-aligned (1) or bandwidth-efficient (0) mode; write it only while the block is idle.
// A result passes through a hold stage, then an output register, on its way to rsp_if.
// Inside a speech frame one octet is taken per cycle while the output is not stalled. The
// table-of-contents entries sit in a synchronous RAM with one write and one read port and
// a registered read. Each frame start, each empty frame, each further TOC entry inside an
// octet and the end of a packet take a parse step of their own, with req_if.ready low.
// Reset clears the parser to expect a CMR, selects octet-aligned mode and empties the
// output path; table contents are not cleared and are read only after being written.
// When rsp_if.ready is low the output register and hold stage fill, then req_if.ready
// drops; nothing is lost or reordered.
module amr_rtp_payload_deframer_core #(
   parameter int MAX_FRAMES = 16
) (
   input  logic        clock,
   input  logic        reset,
   amrdf_req_if.sink   req_if,
   amrdf_rsp_if.source rsp_if,
   input  logic        csr_wr_en,
   input  logic        csr_wr_data
);

   localparam int CW = $clog2(MAX_FRAMES + 1);
   localparam int IW = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
   localparam logic [CW-1:0] MAX_CNT = CW'(MAX_FRAMES);

   localparam logic [2:0] PH_CMR    = 3'd0;
   localparam logic [2:0] PH_TOC    = 3'd1;
   localparam logic [2:0] PH_SPEECH = 3'd2;
   localparam logic [2:0] PH_DRAIN  = 3'd3;
   localparam logic [2:0] PH_START  = 3'd4;

   localparam logic [1:0] SQ_IDLE = 2'd0;
   localparam logic [1:0] SQ_LOOP = 2'd1;
   localparam logic [1:0] SQ_EOP  = 2'd2;

   logic [1:0]             seq_ff, seq_in;
   logic                   eop_ff, eop_in;
   logic                   aligned_ff, aligned_in;
   logic [15:0]            acc_ff, acc_in;
   logic [4:0]             nbits_ff, nbits_in;
   logic [2:0]             phase_ff, phase_in;
   amrdf_pkg::nibble_type  mode_ff, mode_in;
   logic [CW-1:0]          count_ff, count_in;
   logic [CW-1:0]          cf_ff, cf_in;
   logic [7:0]             left_ff, left_in;
   logic                   h_valid_ff, h_valid_in;
   logic                   h_closed_ff, h_closed_in;
   amrdf_pkg::result_type  h_data_ff, h_data_in;
   logic                   o_valid_ff, o_valid_in;
   amrdf_pkg::result_type  o_data_ff, o_data_in;
   logic                   fwd_hit_ff, fwd_hit_in;
   amrdf_pkg::entry_type   fwd_data_ff, fwd_data_in;
   amrdf_pkg::entry_type   rd_data_ff;

   amrdf_pkg::entry_type   entry_mem [MAX_FRAMES];

   logic                   o_free, accept, eop_now, step_go, apply, h_move;
   logic [15:0]            va;
   logic [4:0]             vn;
   amrdf_pkg::entry_type   entry_cur;
   logic [3:0]             need_cmr, need_toc, spk, k_take, nk;
   logic [4:0]             tk_rest;
   logic [7:0]             tk_val, toc_v;
   logic [15:0]            tk_acc;
   logic [IW-1:0]          wr_addr, rd_addr;
   amrdf_pkg::entry_type   wr_data;
   logic                   mem_we;

   logic [15:0]            s_acc;
   logic [4:0]             s_nbits;
   logic [2:0]             s_phase;
   amrdf_pkg::nibble_type  s_mode;
   logic [CW-1:0]          s_count, s_cf;
   logic [7:0]             s_left;
   logic                   s_emit, s_we, s_done, s_last;
   amrdf_pkg::result_type  s_res;

   // ---------------- front end ----------------
   assign o_free       = !o_valid_ff || rsp_if.ready;
   assign req_if.ready = (seq_ff == SQ_IDLE) && (!h_valid_ff || o_free);
   assign accept       = req_if.valid && req_if.ready;
   assign eop_now      = (seq_ff == SQ_IDLE) ? req_if.end_of_packet : eop_ff;
   assign va           = (seq_ff == SQ_IDLE) ? {acc_ff[7:0], req_if.payload_byte} : acc_ff;
   assign vn           = (seq_ff == SQ_IDLE) ? (nbits_ff + 5'd8) : nbits_ff;
   assign entry_cur    = fwd_hit_ff ? fwd_data_ff : rd_data_ff;

   // ---------------- bit extraction ----------------
   assign need_cmr = aligned_ff ? 4'd8 : 4'd4;
   assign need_toc = aligned_ff ? 4'd8 : 4'd6;
   assign spk      = (left_ff >= 8'd8) ? 4'd8 : left_ff[3:0];

   always_comb begin
      unique case (phase_ff)
         PH_CMR:  k_take = need_cmr;
         PH_TOC:  k_take = need_toc;
         default: k_take = spk;
      endcase
   end

   assign tk_rest = vn - {1'b0, k_take};
   assign tk_val  = 8'(va >> tk_rest) & 8'((9'd1 << k_take) - 9'd1);
   assign tk_acc  = va & 16'((17'd1 << tk_rest) - 17'd1);
   assign toc_v   = aligned_ff ? tk_val : {tk_val[5:0], 2'b00};

   // ---------------- one parse step ----------------
   always_comb begin
      s_acc   = va;
      s_nbits = vn;
      s_phase = phase_ff;
      s_mode  = mode_ff;
      s_count = count_ff;
      s_cf    = cf_ff;
      s_left  = left_ff;
      s_emit  = 1'b0;
      s_we    = 1'b0;
      s_done  = 1'b0;
      s_last  = 1'b0;
      nk      = 4'd0;
      s_res   = '0;
      s_res.requested_mode = mode_ff;
      if (seq_ff == SQ_EOP) begin
         s_acc   = '0;
         s_nbits = '0;
         s_phase = PH_CMR;
         s_count = '0;
         s_cf    = '0;
         s_left  = '0;
         s_done  = 1'b1;
         s_last  = 1'b1;
         if (phase_ff != PH_DRAIN) begin
            s_emit       = 1'b1;
            s_res.status = amrdf_pkg::ST_TRUNC;
            if (phase_ff == PH_SPEECH) begin
               s_res.frame_index = 4'(cf_ff);
               s_res.frame_type  = entry_cur.ft;
               s_res.quality     = entry_cur.q;
            end else begin
               s_res.frame_index = 4'(count_ff);
            end
            s_res.last_result = 1'b1;
         end
      end else begin
         unique case (phase_ff)
            PH_CMR: begin
               s_acc   = tk_acc;
               s_nbits = tk_rest;
               s_mode  = aligned_ff ? tk_val[7:4] : tk_val[3:0];
               s_phase = PH_TOC;
            end
            PH_TOC: begin
               s_acc   = tk_acc;
               s_nbits = tk_rest;
               if (count_ff >= MAX_CNT) begin
                  s_emit            = 1'b1;
                  s_res.status      = amrdf_pkg::ST_OVF;
                  s_res.frame_index = 4'(count_ff);
                  s_res.frame_type  = toc_v[6:3];
                  s_res.quality     = toc_v[2];
                  s_phase           = PH_DRAIN;
               end else begin
                  s_we    = 1'b1;
                  s_count = count_ff + CW'(1);
                  if (!toc_v[7]) begin
                     s_cf    = '0;
                     s_phase = PH_START;
                  end
               end
            end
            PH_SPEECH: begin
               s_acc               = tk_acc;
               s_nbits             = tk_rest;
               s_left              = left_ff - {4'd0, spk};
               s_emit              = 1'b1;
               s_res.status        = amrdf_pkg::ST_SPEECH;
               s_res.speech_byte   = 8'(tk_val << (4'd8 - spk));
               s_res.frame_index   = 4'(cf_ff);
               s_res.frame_type    = entry_cur.ft;
               s_res.quality       = entry_cur.q;
               s_res.last_of_frame = (s_left == 8'd0);
               if (s_left == 8'd0) begin
                  s_cf    = cf_ff + CW'(1);
                  s_phase = PH_START;
               end
            end
            PH_START: begin
               if (cf_ff < count_ff) begin
                  if (!entry_cur.ft[3]) begin
                     s_left  = amrdf_pkg::frame_len(entry_cur.ft[2:0], aligned_ff);
                     s_phase = PH_SPEECH;
                  end else begin
                     s_emit              = 1'b1;
                     s_res.status        = amrdf_pkg::ST_EMPTY;
                     s_res.frame_index   = 4'(cf_ff);
                     s_res.frame_type    = entry_cur.ft;
                     s_res.quality       = entry_cur.q;
                     s_res.last_of_frame = 1'b1;
                     s_cf                = cf_ff + CW'(1);
                  end
               end else begin
                  s_left  = '0;
                  s_phase = PH_DRAIN;
               end
            end
            default: begin
               s_phase = PH_DRAIN;
            end
         endcase
         if (s_phase == PH_DRAIN) begin
            s_acc   = '0;
            s_nbits = '0;
         end
         // does the following step of this beat run out of bits?
         nk = (s_left >= 8'd8) ? 4'd8 : s_left[3:0];
         unique case (s_phase)
            PH_DRAIN: s_done = 1'b1;
            PH_START: s_done = 1'b0;
            PH_CMR:   s_done = s_nbits < {1'b0, need_cmr};
            PH_TOC:   s_done = s_nbits < {1'b0, need_toc};
            default:  s_done = s_nbits < {1'b0, nk};
         endcase
         s_last            = s_done && !(eop_now && (s_phase != PH_DRAIN));
         s_res.last_result = s_last;
      end
   end

   assign step_go = !(s_emit && h_valid_ff && !o_free);
   assign apply   = step_go && ((seq_ff == SQ_LOOP) || (seq_ff == SQ_EOP) || accept);
   assign h_move  = h_valid_ff && o_free && (h_closed_ff || (apply && s_emit));

   // ---------------- next state ----------------
   always_comb begin
      seq_in     = seq_ff;
      eop_in     = eop_ff;
      aligned_in = aligned_ff;
      acc_in     = acc_ff;
      nbits_in   = nbits_ff;
      phase_in   = phase_ff;
      mode_in    = mode_ff;
      count_in   = count_ff;
      cf_in      = cf_ff;
      left_in    = left_ff;
      if (csr_wr_en) begin
         aligned_in = csr_wr_data;
      end
      if (accept) begin
         eop_in = req_if.end_of_packet;
      end
      if (apply) begin
         acc_in   = s_acc;
         nbits_in = s_nbits;
         phase_in = s_phase;
         mode_in  = s_mode;
         count_in = s_count;
         cf_in    = s_cf;
         left_in  = s_left;
         if (!s_done) begin
            seq_in = SQ_LOOP;
         end else if (eop_now && (seq_ff != SQ_EOP)) begin
            seq_in = SQ_EOP;
         end else begin
            seq_in = SQ_IDLE;
         end
      end
   end

   // hold stage: a result waits here until its last_result flag is known
   always_comb begin
      h_valid_in  = h_valid_ff;
      h_closed_in = h_closed_ff;
      h_data_in   = h_data_ff;
      if (apply && s_emit) begin
         h_valid_in  = 1'b1;
         h_closed_in = s_done;
         h_data_in   = s_res;
      end else if (h_move) begin
         h_valid_in = 1'b0;
      end else if (apply && s_done && h_valid_ff && !h_closed_ff) begin
         h_closed_in           = 1'b1;
         h_data_in.last_result = s_last;
      end
   end

   always_comb begin
      o_valid_in = o_valid_ff;
      o_data_in  = o_data_ff;
      if (o_free) begin
         o_valid_in = h_move;
      end
      if (h_move) begin
         o_data_in = h_data_ff;
      end
   end

   // ---------------- entry table ----------------
   assign mem_we      = apply && s_we;
   assign wr_addr     = count_ff[IW-1:0];
   assign wr_data     = '{ft: toc_v[6:3], q: toc_v[2]};
   assign rd_addr     = cf_in[IW-1:0];
   assign fwd_hit_in  = mem_we && (wr_addr == rd_addr);
   assign fwd_data_in = wr_data;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         entry_mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= entry_mem[rd_addr];
   end

   // ---------------- registers ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         seq_ff      <= SQ_IDLE;
         eop_ff      <= 1'b0;
         aligned_ff  <= 1'b1;
         acc_ff      <= '0;
         nbits_ff    <= '0;
         phase_ff    <= PH_CMR;
         mode_ff     <= '0;
         count_ff    <= '0;
         cf_ff       <= '0;
         left_ff     <= '0;
         h_valid_ff  <= 1'b0;
         h_closed_ff <= 1'b0;
         o_valid_ff  <= 1'b0;
         fwd_hit_ff  <= 1'b0;
      end else begin
         seq_ff      <= seq_in;
         eop_ff      <= eop_in;
         aligned_ff  <= aligned_in;
         acc_ff      <= acc_in;
         nbits_ff    <= nbits_in;
         phase_ff    <= phase_in;
         mode_ff     <= mode_in;
         count_ff    <= count_in;
         cf_ff       <= cf_in;
         left_ff     <= left_in;
         h_valid_ff  <= h_valid_in;
         h_closed_ff <= h_closed_in;
         o_valid_ff  <= o_valid_in;
         fwd_hit_ff  <= fwd_hit_in;
      end
   end

   always_ff @(posedge clock) begin
      h_data_ff   <= h_data_in;
      o_data_ff   <= o_data_in;
      fwd_data_ff <= fwd_data_in;
   end

   // ---------------- result port ----------------
   assign rsp_if.valid          = o_valid_ff;
   assign rsp_if.status         = o_data_ff.status;
   assign rsp_if.speech_byte    = o_data_ff.speech_byte;
   assign rsp_if.frame_index    = o_data_ff.frame_index;
   assign rsp_if.frame_type     = o_data_ff.frame_type;
   assign rsp_if.quality        = o_data_ff.quality;
   assign rsp_if.requested_mode = o_data_ff.requested_mode;
   assign rsp_if.last_of_frame  = o_data_ff.last_of_frame;
   assign rsp_if.last_result    = o_data_ff.last_result;

   // ---------------- checks ----------------
   a_speech_live: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_SPEECH) |-> ((left_ff != 8'd0) && (cf_ff < count_ff)))
      else $error("speech phase without bits left or without a table entry");

   a_hold_no_overrun: assert property (@(posedge clock) disable iff (reset)
      (h_valid_ff && !o_free) |-> !(apply && s_emit))
      else $error("new result written over a blocked hold stage");

   a_eop_clears: assert property (@(posedge clock) disable iff (reset)
      ((seq_ff == SQ_EOP) && apply) |=>
         ((seq_ff == SQ_IDLE) && (phase_ff == PH_CMR) && (count_ff == '0) && (nbits_ff == '0)))
      else $error("end of packet did not return the parser to its start");

   a_flag_lof: assert property (@(posedge clock) disable iff (reset)
      (rsp_if.valid && ((rsp_if.status == amrdf_pkg::ST_TRUNC) ||
                        (rsp_if.status == amrdf_pkg::ST_OVF))) |-> !rsp_if.last_of_frame)
      else $error("error beat marked as end of frame");

endmodule

>>> test/tb_amr_rtp_payload_deframer_core.sv
`timescale 1ns / 1ps
// Self-checking testbench for the AMR-NB RTP payload deframer core.
module tb_amr_rtp_payload_deframer_core;

   localparam int MAX_FRAMES     = 16;
   localparam int RANDOM_OCTETS  = 400;
   localparam int MODE_SPAN      = 90;
   localparam int SETTLE_CYCLES  = 40;
   localparam int DRAIN_CYCLES   = 40;
   localparam int QUIET_LIMIT    = 5000;
   localparam int SHOWN_ERRORS   = 10;

   localparam int AMR_CLASS_BITS [8] = '{95, 103, 118, 134, 148, 159, 204, 244};

   localparam int SHAPE_GOOD  = 0;
   localparam int SHAPE_TRUNC = 1;
   localparam int SHAPE_WIDE  = 2;
   localparam int SHAPE_OVF   = 3;
   localparam int SHAPE_NOISE = 4;

   localparam logic [1:0] PH_CMR    = 2'd0;
   localparam logic [1:0] PH_TOC    = 2'd1;
   localparam logic [1:0] PH_SPEECH = 2'd2;
   localparam logic [1:0] PH_DRAIN  = 2'd3;

   typedef enum logic {STIM_OCTET, STIM_MODE} stim_kind_type;

   typedef struct packed {
      stim_kind_type kind;
      logic [7:0]    octet;
      logic          eop;
   } stim_type;

   logic       clock       = 1'b0;
   logic       reset       = 1'b1;
   logic       drv_valid   = 1'b0;
   logic [7:0] drv_byte    = 8'h00;
   logic       drv_eop     = 1'b0;
   logic       rsp_ready   = 1'b0;
   logic       csr_we      = 1'b0;
   logic       csr_wd      = 1'b0;

   amrdf_req_if req_ch ();
   amrdf_rsp_if rsp_ch ();

   assign req_ch.valid         = drv_valid;
   assign req_ch.payload_byte  = drv_byte;
   assign req_ch.end_of_packet = drv_eop;
   assign rsp_ch.ready         = rsp_ready;

   amr_rtp_payload_deframer_core #(.MAX_FRAMES(MAX_FRAMES)) u_top (
      .clock       (clock),
      .reset       (reset),
      .req_if      (req_ch),
      .rsp_if      (rsp_ch),
      .csr_wr_en   (csr_we),
      .csr_wr_data (csr_wd)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   // deframer shadow state
   logic                   aligned_mode = 1'b1;
   logic [15:0]            bit_buf      = 16'h0000;
   int                     bit_cnt      = 0;
   logic [1:0]             phase        = PH_CMR;
   logic [3:0]             cmr_seen     = 4'h0;
   amrdf_pkg::entry_type   toc [MAX_FRAMES];
   int                     toc_count    = 0;
   int                     frame_no     = 0;
   int                     bits_left    = 0;
   amrdf_pkg::result_type  pending_results [$];

   stim_type     stim_q [$];
   int           stim_pos     = 0;
   logic         pkt_bits [$];

   int beats_in      = 0;
   int beats_issued  = 0;
   int packets_in    = 0;
   int mode_writes   = 0;
   int mismatches    = 0;
   int results_seen  = 0;
   int speech_seen   = 0;
   int empty_seen    = 0;
   int trunc_seen    = 0;
   int ovf_seen      = 0;
   int quiet_cycles  = 0;

   function automatic void log_result(amrdf_pkg::status_type st, logic [7:0] sb,
                                      logic [3:0] idx, logic [3:0] ft, logic q, logic lof);
      amrdf_pkg::result_type r;
      r.status         = st;
      r.speech_byte    = sb;
      r.frame_index    = idx;
      r.frame_type     = ft;
      r.quality        = q;
      r.requested_mode = cmr_seen;
      r.last_of_frame  = lof;
      r.last_result    = 1'b0;
      pending_results.push_back(r);
   endfunction

   function automatic logic [7:0] pull_bits(int k);
      int          rest;
      logic [31:0] w;
      rest    = bit_cnt - k;
      w       = (32'(bit_buf) >> rest) & ((32'd1 << k) - 32'd1);
      bit_cnt = rest;
      bit_buf = 16'(32'(bit_buf) & ((32'd1 << rest) - 32'd1));
      return w[7:0];
   endfunction

   // emit markers for empty frames, stop at the next frame that carries speech
   function automatic void next_speech_frame();
      amrdf_pkg::entry_type ent;
      while (frame_no < toc_count && frame_no < MAX_FRAMES) begin
         ent = toc[frame_no];
         if (ent.ft < 4'd8) begin
            bits_left = AMR_CLASS_BITS[ent.ft[2:0]];
            if (aligned_mode)
               bits_left = (bits_left + 7) / 8 * 8;
            phase = PH_SPEECH;
            return;
         end
         log_result(amrdf_pkg::ST_EMPTY, 8'h00, 4'(frame_no), ent.ft, ent.q, 1'b1);
         frame_no++;
      end
      bits_left = 0;
      phase     = PH_DRAIN;
   endfunction

   function automatic void predict_octet(logic [7:0] octet, logic eop);
      int                    start;
      int                    need;
      int                    k;
      logic [7:0]            v;
      logic [3:0]            ft;
      logic                  q;
      logic                  f;
      logic                  done;
      amrdf_pkg::entry_type  ent;
      amrdf_pkg::result_type r;
      start   = pending_results.size();
      bit_buf = {bit_buf[7:0], octet};
      bit_cnt += 8;
      done    = 1'b0;
      while (!done) begin
         case (phase)
            PH_CMR: begin
               need = aligned_mode ? 8 : 4;
               if (bit_cnt < need) begin
                  done = 1'b1;
               end else begin
                  v        = pull_bits(need);
                  cmr_seen = aligned_mode ? v[7:4] : v[3:0];
                  phase    = PH_TOC;
               end
            end
            PH_TOC: begin
               need = aligned_mode ? 8 : 6;
               if (bit_cnt < need) begin
                  done = 1'b1;
               end else begin
                  v = pull_bits(need);
                  if (!aligned_mode)
                     v = v << 2;
                  f  = v[7];
                  ft = v[6:3];
                  q  = v[2];
                  if (toc_count >= MAX_FRAMES) begin
                     log_result(amrdf_pkg::ST_OVF, 8'h00, 4'(toc_count), ft, q, 1'b0);
                     phase = PH_DRAIN;
                  end else begin
                     toc[toc_count] = {ft, q};
                     toc_count++;
                     if (!f) begin
                        frame_no = 0;
                        next_speech_frame();
                     end
                  end
               end
            end
            PH_SPEECH: begin
               k = bits_left >= 8 ? 8 : bits_left;
               if (k == 0 || frame_no >= toc_count || frame_no >= MAX_FRAMES) begin
                  phase = PH_DRAIN;
               end else if (bit_cnt < k) begin
                  done = 1'b1;
               end else begin
                  v         = pull_bits(k);
                  bits_left -= k;
                  ent       = toc[frame_no];
                  log_result(amrdf_pkg::ST_SPEECH, v << (8 - k), 4'(frame_no), ent.ft, ent.q,
                             bits_left == 0);
                  if (bits_left == 0) begin
                     frame_no++;
                     next_speech_frame();
                  end
               end
            end
            default: begin
               bit_buf = 16'h0000;
               bit_cnt = 0;
               done    = 1'b1;
            end
         endcase
      end
      if (eop) begin
         if (phase == PH_SPEECH && frame_no < MAX_FRAMES) begin
            ent = toc[frame_no];
            log_result(amrdf_pkg::ST_TRUNC, 8'h00, 4'(frame_no), ent.ft, ent.q, 1'b0);
         end else if (phase != PH_DRAIN) begin
            log_result(amrdf_pkg::ST_TRUNC, 8'h00, 4'(toc_count), 4'h0, 1'b0, 1'b0);
         end
         bit_buf   = 16'h0000;
         bit_cnt   = 0;
         phase     = PH_CMR;
         toc_count = 0;
         frame_no  = 0;
         bits_left = 0;
      end
      if (pending_results.size() > start) begin
         r             = pending_results.pop_back();
         r.last_result = 1'b1;
         pending_results.push_back(r);
      end
   endfunction

   function automatic void check_result(amrdf_pkg::result_type got);
      amrdf_pkg::result_type want;
      results_seen++;
      case (got.status)
         amrdf_pkg::ST_SPEECH: speech_seen++;
         amrdf_pkg::ST_EMPTY:  empty_seen++;
         amrdf_pkg::ST_TRUNC:  trunc_seen++;
         default:              ovf_seen++;
      endcase
      if (pending_results.size() == 0) begin
         mismatches++;
         if (mismatches <= SHOWN_ERRORS)
            $display("%0t: unexpected result st=%0d byte=%02h idx=%0d ft=%0d q=%0d",
                     $time, got.status, got.speech_byte, got.frame_index,
                     got.frame_type, got.quality);
         return;
      end
      want = pending_results.pop_front();
      if (got !== want) begin
         mismatches++;
         if (mismatches <= SHOWN_ERRORS) begin
            $display("%0t: exp st=%0d byte=%02h idx=%0d ft=%0d q=%0d cmr=%0d lof=%0d last=%0d",
                     $time, want.status, want.speech_byte, want.frame_index, want.frame_type,
                     want.quality, want.requested_mode, want.last_of_frame, want.last_result);
            $display("%0t: got st=%0d byte=%02h idx=%0d ft=%0d q=%0d cmr=%0d lof=%0d last=%0d",
                     $time, got.status, got.speech_byte, got.frame_index, got.frame_type,
                     got.quality, got.requested_mode, got.last_of_frame, got.last_result);
         end
      end
   endfunction

   function automatic void add_octet(logic [7:0] b, logic e);
      stim_type s;
      s.kind  = STIM_OCTET;
      s.octet = b;
      s.eop   = e;
      stim_q.push_back(s);
   endfunction

   function automatic void add_mode(logic aligned);
      stim_type s;
      s.kind  = STIM_MODE;
      s.octet = {7'd0, aligned};
      s.eop   = 1'b0;
      stim_q.push_back(s);
   endfunction

   function automatic void put_bits(logic [7:0] v, int n);
      for (int i = n - 1; i >= 0; i--)
         pkt_bits.push_back(v[i]);
   endfunction

   // pad to whole octets, optionally cut short, mark the last octet
   function automatic void flush_packet(int cut);
      int         nbytes;
      logic [7:0] b;
      while (pkt_bits.size() % 8 != 0)
         put_bits(8'($urandom_range(0, 1)), 1);
      nbytes = pkt_bits.size() / 8;
      if (cut > 0 && cut < nbytes)
         nbytes = cut;
      for (int i = 0; i < nbytes; i++) begin
         for (int j = 0; j < 8; j++)
            b[7 - j] = pkt_bits[i * 8 + j];
         add_octet(b, i == nbytes - 1);
      end
      pkt_bits.delete();
   endfunction

   function automatic void build_packet(logic aligned, int shape);
      int         nent;
      int         len;
      int         cut;
      logic [3:0] ft_list [$];
      logic [3:0] ft;
      logic       f;
      if (shape == SHAPE_NOISE) begin
         nent = $urandom_range(1, 6);
         for (int i = 0; i < nent; i++)
            add_octet(8'($urandom_range(0, 255)), i == nent - 1);
         return;
      end
      case (shape)
         SHAPE_WIDE: nent = MAX_FRAMES;
         SHAPE_OVF:  nent = $urandom_range(MAX_FRAMES + 1, MAX_FRAMES + 2);
         default:    nent = ($urandom_range(0, 3) == 0) ? $urandom_range(3, 5)
                                                        : $urandom_range(1, 2);
      endcase
      put_bits(8'($urandom_range(0, 15)), 4);
      if (aligned)
         put_bits(8'($urandom_range(0, 15)), 4);
      for (int i = 0; i < nent; i++) begin
         if (shape == SHAPE_WIDE || nent > 2)
            ft = ($urandom_range(0, 7) == 0) ? 4'($urandom_range(0, 7))
                                             : 4'($urandom_range(8, 15));
         else
            ft = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(8, 15))
                                             : 4'($urandom_range(0, 7));
         f = (i != nent - 1) || (shape == SHAPE_OVF);
         ft_list.push_back(ft);
         put_bits({2'b00, f, ft, 1'($urandom_range(0, 1))}, 6);
         if (aligned)
            put_bits(8'($urandom_range(0, 3)), 2);
      end
      if (shape == SHAPE_OVF) begin
         for (int i = $urandom_range(0, 2); i > 0; i--)
            put_bits(8'($urandom_range(0, 255)), 8);
      end else begin
         foreach (ft_list[i]) begin
            if (ft_list[i] < 4'd8) begin
               len = AMR_CLASS_BITS[ft_list[i][2:0]];
               if (aligned)
                  len = (len + 7) / 8 * 8;
               for (int j = 0; j < len; j++)
                  put_bits(8'($urandom_range(0, 1)), 1);
            end
         end
         if (shape == SHAPE_GOOD && $urandom_range(0, 3) == 0) begin
            for (int i = $urandom_range(1, 2); i > 0; i--)
               put_bits(8'($urandom_range(0, 255)), 8);
         end
      end
      cut = 0;
      if (shape == SHAPE_TRUNC && (pkt_bits.size() + 7) / 8 > 1)
         cut = $urandom_range(1, (pkt_bits.size() + 7) / 8 - 1);
      flush_packet(cut);
   endfunction

   // payload sender: bursts of beats with random gaps, mode writes only when drained
   int burst_left = 0;
   int gap_left   = 0;
   int settle_cnt = 0;

   always @(negedge clock) begin : sender
      logic next_valid;
      logic next_we;
      next_valid = 1'b0;
      next_we    = 1'b0;
      if (!reset) begin
         if (drv_valid && beats_in != beats_issued) begin
            next_valid = 1'b1;
         end else if (gap_left > 0) begin
            gap_left--;
         end else if (stim_pos < stim_q.size()) begin
            if (stim_q[stim_pos].kind == STIM_OCTET) begin
               drv_byte   <= stim_q[stim_pos].octet;
               drv_eop    <= stim_q[stim_pos].eop;
               next_valid = 1'b1;
               stim_pos++;
               beats_issued++;
               if (burst_left > 0) begin
                  burst_left--;
               end else begin
                  burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                           : $urandom_range(1, 12);
                  gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5);
               end
            end else if (pending_results.size() == 0 && beats_in == beats_issued) begin
               if (settle_cnt >= SETTLE_CYCLES) begin
                  next_we    = 1'b1;
                  csr_wd     <= stim_q[stim_pos].octet[0];
                  settle_cnt = 0;
                  stim_pos++;
               end else begin
                  settle_cnt++;
               end
            end else begin
               settle_cnt = 0;
            end
         end
      end
      drv_valid <= next_valid;
      csr_we    <= next_we;
   end

   // result receiver: backpressure style is redrawn whenever its random stall counter runs out
   int stall_left  = 0;
   int stall_style = 0;

   always @(negedge clock) begin
      if (stall_left == 0) begin
         stall_style = $urandom_range(0, 3);
         stall_left  = $urandom_range(20, 120);
      end else begin
         stall_left--;
      end
      case (stall_style)
         0:       rsp_ready <= 1'b1;
         1:       rsp_ready <= 1'($urandom_range(0, 1));
         2:       rsp_ready <= ($urandom_range(0, 3) == 0);
         default: rsp_ready <= stall_left[2];
      endcase
   end

   always @(posedge clock) begin : monitor
      logic fired;
      if (!reset) begin
         fired = 1'b0;
         if (rsp_ch.valid && rsp_ch.ready) begin
            check_result({rsp_ch.status, rsp_ch.speech_byte, rsp_ch.frame_index,
                          rsp_ch.frame_type, rsp_ch.quality, rsp_ch.requested_mode,
                          rsp_ch.last_of_frame, rsp_ch.last_result});
            fired = 1'b1;
         end
         if (req_ch.valid && req_ch.ready) begin
            predict_octet(req_ch.payload_byte, req_ch.end_of_packet);
            beats_in++;
            if (req_ch.end_of_packet)
               packets_in++;
            fired = 1'b1;
         end
         if (csr_we) begin
            aligned_mode = csr_wd;
            mode_writes++;
         end
         if (fired) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT) begin
               $display("watchdog: no beat moved for %0d cycles", QUIET_LIMIT);
               $display("amr_rtp_payload_deframer_core regression: fail");
               $finish;
            end
         end
      end
   end

   initial begin : stimulus
      logic gen_aligned;
      int   base;
      int   last_switch;
      int   pkt_no;
      int   shape;
      int   pick;

      add_mode(1'b1);
      // CMR octet alone, packet ends while waiting for the table
      add_octet(8'hFF, 1'b1);
      // two empty frames, no speech, end falls in the drained part
      add_octet(8'h00, 1'b0);
      add_octet(8'hFF, 1'b0);
      add_octet(8'h40, 1'b1);
      // speech frame cut short; switch to bandwidth-efficient inside the frame
      add_octet(8'h7A, 1'b0);
      add_octet(8'h3D, 1'b0);
      add_octet(8'hFF, 1'b0);
      add_octet(8'h00, 1'b0);
      add_mode(1'b0);
      add_octet(8'hA5, 1'b0);
      add_octet(8'h5A, 1'b1);
      // bandwidth-efficient: empty frame, then a speech frame truncated
      add_octet(8'hCF, 1'b0);
      add_octet(8'h03, 1'b0);
      add_octet(8'h81, 1'b1);
      // bandwidth-efficient: packet ends inside the first table entry
      add_octet(8'h0F, 1'b1);
      add_mode(1'b1);

      gen_aligned = 1'b1;
      base        = stim_q.size();
      last_switch = base;
      pkt_no      = 0;
      while (stim_q.size() - base < RANDOM_OCTETS) begin
         pick = $urandom_range(0, 9);
         if (pkt_no % 7 == 3)
            shape = SHAPE_OVF;
         else if (pick <= 5)
            shape = SHAPE_GOOD;
         else if (pick <= 7)
            shape = SHAPE_TRUNC;
         else if (pick == 8)
            shape = SHAPE_WIDE;
         else
            shape = SHAPE_NOISE;
         build_packet(gen_aligned, shape);
         pkt_no++;
         if (stim_q.size() - last_switch >= MODE_SPAN) begin
            gen_aligned = !gen_aligned;
            add_mode(gen_aligned);
            last_switch = stim_q.size();
         end
      end

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (stim_pos < stim_q.size() || drv_valid || pending_results.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("sent %0d payload octets in %0d packets across %0d mode writes",
               beats_in, packets_in, mode_writes);
      $display("checked %0d results: %0d speech, %0d empty, %0d truncated, %0d overflow",
               results_seen, speech_seen, empty_seen, trunc_seen, ovf_seen);
      if (mismatches == 0) begin
         $display("amr_rtp_payload_deframer_core regression: pass");
      end else begin
         $display("%0d mismatches", mismatches);
         $display("amr_rtp_payload_deframer_core regression: fail");
      end
      $finish;
   end

endmodule

>>> sim.f
hdl/amrdf_pkg.sv
hdl/amrdf_if.sv
hdl/amr_rtp_payload_deframer_core.sv
test/tb_amr_rtp_payload_deframer_core.sv
